// File: hdl/stable_matching_engine_top_defines.svh
// assertion macros for the stable matching engine
`ifndef STABLE_MATCHING_ENGINE_TOP_DEFINES_SVH
`define STABLE_MATCHING_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define SME_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define SME_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sme_pkg.sv
// shared types and constants of the stable matching engine
package sme_pkg;

   localparam int FIELD_W = 6;
   localparam int CFG_W   = 7;

   typedef enum logic [1:0] {
      OP_LOAD_PREF = 2'd0,
      OP_LOAD_RANK = 2'd1,
      OP_RUN       = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND,
      ST_SCAN,
      ST_NC,
      ST_PROP,
      ST_PREF,
      ST_HELD,
      ST_RANK1,
      ST_RANK2,
      ST_DISP,
      ST_E_NC,
      ST_E_PREF,
      ST_E_OUT
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] proposer;
      logic [FIELD_W-1:0] acceptor;
      logic               matched;
      logic               last;
   } pair_type;

endpackage

// File: hdl/stable_matching_engine_top.sv
// top level of the stable matching engine
//
// usage
//   req channel (valid/stall) carries one command word: op 0 stores a proposer's
//   preference entry, op 1 stores an acceptor's rank of a proposer, op 2 runs
//   proposer-optimal stable matching and then returns one rsp word per proposer
//   in index order, the final one flagged with rsp_last. op 3 is dropped.
//   csr_wr_en/csr_wr_data set the pair count; write it only while idle.
// timing
//   a load does not make the block busy; req_stall stays low for the next word.
//   a run passes a setup state, then per round a round state and a proposer
//   scan, a next-choice read per queued proposer and per proposal up to list,
//   holder, two rank reads and next-choice update, one closing round check,
//   then a next-choice and list read per rsp word; proposals bounded by n squared.
//   req_stall stays high until the last word has moved into the output register.
// reset
//   control state clears, the pair count returns to MAX_PAIRS; stored lists
//   and ranks are undefined until loaded.
// back-pressure
//   rsp_stall freezes the output register and, while it is full, holds the sequencer's offered word.
module stable_matching_engine_top #(
   parameter int MAX_PAIRS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [sme_pkg::CFG_W-1:0]   csr_wr_data,
   // command words
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [sme_pkg::FIELD_W-1:0] req_person,
   input  logic [sme_pkg::FIELD_W-1:0] req_position,
   input  logic [sme_pkg::FIELD_W-1:0] req_partner,
   // result words
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sme_pkg::FIELD_W-1:0] rsp_proposer,
   output logic [sme_pkg::FIELD_W-1:0] rsp_acceptor,
   output logic                        rsp_matched,
   output logic                        rsp_last
);

   `include "stable_matching_engine_top_defines.svh"

   localparam int CW = $clog2(MAX_PAIRS + 1);

   // pair count register and its clamp into 1..MAX_PAIRS
   logic [sme_pkg::CFG_W-1:0] pair_count_ff, pair_count_in;
   logic [CW-1:0]             active_n;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   sme_pkg::pair_type rsp_pair_ff, rsp_pair_in;

   // sequencer hand-off
   logic              res_valid;
   sme_pkg::pair_type res;
   logic              res_take;
   logic              last_ok;

   assign pair_count_in = csr_wr_en ? csr_wr_data : pair_count_ff;

   always_comb begin
      if (pair_count_ff == '0) begin
         active_n = CW'(1);
      end else if (pair_count_ff > sme_pkg::CFG_W'(MAX_PAIRS)) begin
         active_n = CW'(MAX_PAIRS);
      end else begin
         active_n = pair_count_ff[CW-1:0];
      end
   end

   // the output register takes a word when empty or when its word leaves
   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_pair_in  = (res_valid && res_take) ? res : rsp_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= sme_pkg::CFG_W'(MAX_PAIRS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_count_ff <= pair_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pair_ff <= rsp_pair_in;
   end

   sme_ctrl #(.MAX_PAIRS(MAX_PAIRS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .active_n    (active_n),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_op       (req_op),
      .in_person   (req_person),
      .in_position (req_position),
      .in_partner  (req_partner),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_proposer = rsp_pair_ff.proposer;
   assign rsp_acceptor = rsp_pair_ff.acceptor;
   assign rsp_matched  = rsp_pair_ff.matched;
   assign rsp_last     = rsp_pair_ff.last;

   // the flagged final word belongs to the highest proposer in use
   assign last_ok = ({1'b0, rsp_proposer} == sme_pkg::CFG_W'(active_n) - sme_pkg::CFG_W'(1));

   // a run command makes the block busy on the very next cycle
   `SME_ASSERT_NXT(a_run_busy, req_valid && !req_stall && req_op == sme_pkg::OP_RUN, req_stall, "run not started")
   // no pair is offered while the block takes commands
   `SME_ASSERT_IMP(a_idle_quiet, !req_stall, !res_valid, "pair offered while idle")
   // final flag only on the highest proposer in use
   `SME_ASSERT_IMP(a_last_index, rsp_valid && rsp_last, last_ok, "last flag on wrong proposer")
   // an unmatched proposer reports acceptor zero
   `SME_ASSERT_IMP(a_unmatched_zero, rsp_valid && !rsp_matched, rsp_acceptor == '0, "unmatched acceptor not zero")

endmodule

// File: hdl/sme_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module sme_ram #(
   parameter int DATA_W = 6,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sme_ctrl.sv
// matching sequencer: list and rank stores, proposal loop and pair readout
module sme_ctrl #(
   parameter int MAX_PAIRS = 64,
   localparam int IW = $clog2(MAX_PAIRS),
   localparam int CW = $clog2(MAX_PAIRS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CW-1:0]               active_n,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  logic [1:0]                  in_op,
   input  logic [sme_pkg::FIELD_W-1:0] in_person,
   input  logic [sme_pkg::FIELD_W-1:0] in_position,
   input  logic [sme_pkg::FIELD_W-1:0] in_partner,
   output logic                        res_valid,
   output sme_pkg::pair_type           res,
   input  logic                        res_take
);

   sme_pkg::state_type state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        a_ff, a_in;
   logic [IW-1:0]        h_ff, h_in;
   logic [IW-1:0]        rank_h_ff, rank_h_in;
   logic [CW-1:0]        cur_nc_ff, cur_nc_in;
   logic [MAX_PAIRS-1:0] queued_ff, queued_in;
   logic [MAX_PAIRS-1:0] engaged_ff, engaged_in;
   logic [MAX_PAIRS-1:0] exhausted_ff, exhausted_in;
   logic [MAX_PAIRS-1:0] held_vld_ff, held_vld_in;
   logic [MAX_PAIRS-1:0] nc_vld_ff, nc_vld_in;

   logic [MAX_PAIRS-1:0] in_use;
   logic [MAX_PAIRS-1:0] round_set;
   logic                 accept;
   logic                 in_range;
   logic                 last_idx;
   logic [CW-1:0]        nc_now;
   logic [CW-1:0]        disp_nc;

   // ram ports
   logic            pref_we, rank_we, held_we, nc_we;
   logic [2*IW-1:0] pref_waddr, pref_raddr, rank_waddr, rank_raddr;
   logic [IW-1:0]   pref_wdata, pref_rdata, rank_wdata, rank_rdata;
   logic [IW-1:0]   held_waddr, held_raddr, held_wdata, held_rdata;
   logic [IW-1:0]   nc_waddr, nc_raddr;
   logic [CW-1:0]   nc_wdata, nc_rdata;

   sme_ram #(.DATA_W(IW), .ADDR_W(2*IW)) u_pref (
      .clock(clock), .wr_en(pref_we), .wr_addr(pref_waddr), .wr_data(pref_wdata),
      .rd_addr(pref_raddr), .rd_data(pref_rdata)
   );

   sme_ram #(.DATA_W(IW), .ADDR_W(2*IW)) u_rank (
      .clock(clock), .wr_en(rank_we), .wr_addr(rank_waddr), .wr_data(rank_wdata),
      .rd_addr(rank_raddr), .rd_data(rank_rdata)
   );

   sme_ram #(.DATA_W(IW), .ADDR_W(IW)) u_held (
      .clock(clock), .wr_en(held_we), .wr_addr(held_waddr), .wr_data(held_wdata),
      .rd_addr(held_raddr), .rd_data(held_rdata)
   );

   sme_ram #(.DATA_W(CW), .ADDR_W(IW)) u_nc (
      .clock(clock), .wr_en(nc_we), .wr_addr(nc_waddr), .wr_data(nc_wdata),
      .rd_addr(nc_raddr), .rd_data(nc_rdata)
   );

   always_comb begin
      for (int k = 0; k < MAX_PAIRS; k++) begin
         in_use[k] = (CW'(k) < active_n);
      end
   end

   assign round_set = in_use & ~engaged_ff & ~exhausted_ff;
   assign in_stall  = (state_ff != sme_pkg::ST_IDLE);
   assign accept    = in_valid && !in_stall;
   assign in_range  = ({1'b0, in_person} < sme_pkg::CFG_W'(MAX_PAIRS))
                   && ({1'b0, in_position} < sme_pkg::CFG_W'(MAX_PAIRS))
                   && ({1'b0, in_partner} < sme_pkg::CFG_W'(MAX_PAIRS));
   assign last_idx  = (CW'(idx_ff) == active_n - CW'(1));
   assign nc_now    = nc_vld_ff[idx_ff] ? nc_rdata : '0;
   assign disp_nc   = (nc_vld_ff[h_ff] ? nc_rdata : '0) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sme_pkg::ST_IDLE;
         engaged_ff   <= '0;
         exhausted_ff <= '0;
         held_vld_ff  <= '0;
         nc_vld_ff    <= '0;
         queued_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         engaged_ff   <= engaged_in;
         exhausted_ff <= exhausted_in;
         held_vld_ff  <= held_vld_in;
         nc_vld_ff    <= nc_vld_in;
         queued_ff    <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      a_ff      <= a_in;
      h_ff      <= h_in;
      rank_h_ff <= rank_h_in;
      cur_nc_ff <= cur_nc_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      a_in         = a_ff;
      h_in         = h_ff;
      rank_h_in    = rank_h_ff;
      cur_nc_in    = cur_nc_ff;
      queued_in    = queued_ff;
      engaged_in   = engaged_ff;
      exhausted_in = exhausted_ff;
      held_vld_in  = held_vld_ff;
      nc_vld_in    = nc_vld_ff;

      pref_we    = 1'b0;
      pref_waddr = {in_person[IW-1:0], in_position[IW-1:0]};
      pref_wdata = in_partner[IW-1:0];
      pref_raddr = {idx_ff, cur_nc_ff[IW-1:0]};
      rank_we    = 1'b0;
      rank_waddr = {in_person[IW-1:0], in_partner[IW-1:0]};
      rank_wdata = in_position[IW-1:0];
      rank_raddr = {a_ff, idx_ff};
      held_we    = 1'b0;
      held_waddr = a_ff;
      held_wdata = idx_ff;
      held_raddr = a_ff;
      nc_we      = 1'b0;
      nc_waddr   = idx_ff;
      nc_wdata   = cur_nc_ff;
      nc_raddr   = idx_ff;

      res_valid        = 1'b0;
      res.proposer     = sme_pkg::FIELD_W'(idx_ff);
      res.acceptor     = engaged_ff[idx_ff] ? sme_pkg::FIELD_W'(pref_rdata) : '0;
      res.matched      = engaged_ff[idx_ff];
      res.last         = last_idx;

      unique case (state_ff)
         sme_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (sme_pkg::op_type'(in_op))
                  sme_pkg::OP_LOAD_PREF: pref_we = in_range;
                  sme_pkg::OP_LOAD_RANK: rank_we = in_range;
                  sme_pkg::OP_RUN:       state_in = sme_pkg::ST_INIT;
                  default: ;
               endcase
            end
         end
         sme_pkg::ST_INIT: begin
            // fresh run: every proposer free, every acceptor free, lists at the top
            engaged_in   = '0;
            exhausted_in = '0;
            held_vld_in  = '0;
            nc_vld_in    = '0;
            state_in     = sme_pkg::ST_ROUND;
         end
         sme_pkg::ST_ROUND: begin
            idx_in = '0;
            if (|round_set) begin
               queued_in = round_set;
               state_in  = sme_pkg::ST_SCAN;
            end else begin
               state_in = sme_pkg::ST_E_NC;
            end
         end
         sme_pkg::ST_SCAN: begin
            if (queued_ff[idx_ff]) begin
               state_in = sme_pkg::ST_NC;
            end else if (last_idx) begin
               state_in = sme_pkg::ST_ROUND;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         sme_pkg::ST_NC: begin
            cur_nc_in = nc_now;
            state_in  = sme_pkg::ST_PROP;
         end
         sme_pkg::ST_PROP: begin
            if (cur_nc_ff == active_n) begin
               exhausted_in[idx_ff] = 1'b1;
               if (last_idx) begin
                  state_in = sme_pkg::ST_ROUND;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = sme_pkg::ST_SCAN;
               end
            end else begin
               state_in = sme_pkg::ST_PREF;
            end
         end
         sme_pkg::ST_PREF: begin
            a_in       = pref_rdata;
            held_raddr = pref_rdata;
            if (CW'(pref_rdata) >= active_n) begin
               // acceptor outside the pairs in use: counts as a refusal
               cur_nc_in = cur_nc_ff + CW'(1);
               state_in  = sme_pkg::ST_PROP;
            end else begin
               state_in = sme_pkg::ST_HELD;
            end
         end
         sme_pkg::ST_HELD: begin
            if (!held_vld_ff[a_ff]) begin
               held_we              = 1'b1;
               held_vld_in[a_ff]    = 1'b1;
               engaged_in[idx_ff]   = 1'b1;
               nc_we                = 1'b1;
               nc_vld_in[idx_ff]    = 1'b1;
               if (last_idx) begin
                  state_in = sme_pkg::ST_ROUND;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = sme_pkg::ST_SCAN;
               end
            end else begin
               h_in       = held_rdata;
               rank_raddr = {a_ff, held_rdata};
               state_in   = sme_pkg::ST_RANK1;
            end
         end
         sme_pkg::ST_RANK1: begin
            rank_h_in = rank_rdata;
            state_in  = sme_pkg::ST_RANK2;
         end
         sme_pkg::ST_RANK2: begin
            if (rank_h_ff < rank_rdata) begin
               cur_nc_in = cur_nc_ff + CW'(1);
               state_in  = sme_pkg::ST_PROP;
            end else begin
               // newcomer wins, ties included
               held_we            = 1'b1;
               engaged_in[h_ff]   = 1'b0;
               engaged_in[idx_ff] = 1'b1;
               nc_we              = 1'b1;
               nc_vld_in[idx_ff]  = 1'b1;
               nc_raddr           = h_ff;
               state_in           = sme_pkg::ST_DISP;
            end
         end
         sme_pkg::ST_DISP: begin
            nc_we           = 1'b1;
            nc_waddr        = h_ff;
            nc_wdata        = disp_nc;
            nc_vld_in[h_ff] = 1'b1;
            if (disp_nc == active_n) begin
               exhausted_in[h_ff] = 1'b1;
            end
            if (last_idx) begin
               state_in = sme_pkg::ST_ROUND;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = sme_pkg::ST_SCAN;
            end
         end
         sme_pkg::ST_E_NC: begin
            state_in = sme_pkg::ST_E_PREF;
         end
         sme_pkg::ST_E_PREF: begin
            pref_raddr = {idx_ff, nc_now[IW-1:0]};
            state_in   = sme_pkg::ST_E_OUT;
         end
         sme_pkg::ST_E_OUT: begin
            // keep the list read on this proposer while the word waits
            pref_raddr = {idx_ff, nc_now[IW-1:0]};
            res_valid  = 1'b1;
            if (res_take) begin
               if (last_idx) begin
                  state_in = sme_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = sme_pkg::ST_E_NC;
               end
            end
         end
         default: begin
            state_in = sme_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
